### sv/buddy_pkg.sv
// Shared types and constants for the buddy allocator.
// No dependencies; used by buddy_allocator.
package buddy_pkg;

  // Default pool depth: log2 of the number of minimum blocks
  localparam int LEVELS_DEF = 10;
  // Width of order counters and of the recorded order store (order + 1)
  localparam int K_W = 5;

  // Request opcodes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Response status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOBLK   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DEC,
    S_ASRCH,
    S_APOP,
    S_ASPLIT,
    S_FCHK,
    S_FLOOP,
    S_WRD,
    S_WWT,
    S_PUSH,
    S_QCHK,
    S_RESP
  } state_t;

endpackage

### sv/buddy_allocator.sv
// Binary buddy allocator: free lists in registers, links and recorded orders in RAM.
// Depends on buddy_pkg.
//
// One request is taken at a time. After reset a clearing pass zeroes every entry
// of the recorded-order RAM before the first request is accepted. A request with
// a bad address, opcode or recorded order is answered as invalid. An allocate
// searches upward from the requested order for a non-empty list, pops its head,
// splits it down to the requested order and records the order. A free checks and
// clears the recorded order, then at each merge level walks that order's free list
// one link RAM entry at a time and unlinks the buddy if found; the merged block is
// then pushed, so its time is set by the link RAM walks. A finished response sits
// in an output register while the next request is accepted. A response still
// waiting there holds the next one in its final cycle.
module buddy_allocator #(
  parameter int LEVELS = buddy_pkg::LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [3:0]  req_order,
  input  logic [31:0] req_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] block_address,
  output logic [3:0]  block_order
);

  localparam int NBLK   = 1 << LEVELS;
  localparam int IDX_W  = LEVELS;
  localparam int LINK_W = LEVELS + 1;
  localparam int HI_W   = $clog2(LEVELS + 1);
  localparam int KW     = buddy_pkg::K_W;
  localparam logic [KW-1:0] LEV_K = KW'(LEVELS);

  buddy_pkg::state_t state, state_next;

  // Configuration registers
  logic [31:0] pool_base;
  logic [4:0]  min_level;

  // Request and working registers
  logic [1:0]        r_op;
  logic [3:0]        r_ord;
  logic [31:0]       r_addr;
  logic [KW-1:0]     k;
  logic [IDX_W-1:0]  idx, blk, buddy, clr;
  logic [LINK_W-1:0] cur, prev;
  logic [LINK_W-1:0] heads [LEVELS+1];
  logic              link0_ok;
  logic [1:0]        res_status;
  logic [31:0]       res_baddr;
  logic [3:0]        res_border;

  // Memories
  logic [LINK_W-1:0] nl_mem [NBLK];
  logic [KW-1:0]     ao_mem [NBLK];
  logic [LINK_W-1:0] nl_q, nl_rd;
  logic [KW-1:0]     ao_q;
  logic              nl_rd0;
  logic              nl_re, nl_we, ao_re, ao_we;
  logic [IDX_W-1:0]  nl_raddr, nl_waddr, ao_raddr, ao_waddr;
  logic [LINK_W-1:0] nl_wdata;
  logic [KW-1:0]     ao_wdata;

  // Derived signals
  logic              k_le;
  logic [LINK_W-1:0] head_k, head_dn;
  logic [KW-1:0]     k_dn, ord_k, ord1;
  logic [IDX_W-1:0]  split_blk, node, head_idx;
  logic [31:0]       off, blkno, amask;
  logic              addr_ok;
  logic [IDX_W-1:0]  dec_idx;
  logic              rsp_go;

  assign ord_k     = KW'(r_ord);
  assign ord1      = ord_k + KW'(1);
  assign k_le      = (k <= LEV_K);
  assign head_k    = k_le ? heads[k[HI_W-1:0]] : '0;
  assign head_idx  = IDX_W'(head_k - LINK_W'(1));
  assign k_dn      = k - KW'(1);
  assign head_dn   = heads[k_dn[HI_W-1:0]];
  assign split_blk = idx ^ (IDX_W'(1) << k_dn);
  assign node      = IDX_W'(cur - LINK_W'(1));
  assign nl_rd     = (nl_rd0 && !link0_ok) ? '0 : nl_q;
  assign rsp_go    = !out_valid || out_ready;
  assign in_ready  = (state == buddy_pkg::S_IDLE);

  // Address decode: inside the pool and aligned to a minimum block
  assign off     = r_addr - pool_base;
  assign blkno   = off >> min_level;
  assign amask   = ~(32'hFFFF_FFFF << min_level);
  assign addr_ok = (r_addr >= pool_base) && ((blkno >> LEVELS) == 32'd0) &&
                   ((off & amask) == 32'd0);
  assign dec_idx = blkno[IDX_W-1:0];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= 32'd0;
      min_level <= 5'd4;
    end else if (cfg_wen) begin
      if (cfg_index == 1'b0) pool_base <= cfg_wdata;
      else                   min_level <= cfg_wdata[4:0];
    end
  end

  // Link RAM
  always_ff @(posedge clk) begin
    if (nl_we) nl_mem[nl_waddr] <= nl_wdata;
    if (nl_re) begin
      nl_q   <= nl_mem[nl_raddr];
      nl_rd0 <= (nl_raddr == '0);
    end
  end

  // Recorded-order RAM
  always_ff @(posedge clk) begin
    if (ao_we) ao_mem[ao_waddr] <= ao_wdata;
    if (ao_re) ao_q <= ao_mem[ao_raddr];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      buddy_pkg::S_CLR:    if (clr == '1) state_next = buddy_pkg::S_IDLE;
      buddy_pkg::S_IDLE:   if (in_valid) state_next = buddy_pkg::S_DEC;
      buddy_pkg::S_DEC: begin
        unique case (r_op)
          buddy_pkg::OP_ALLOC: state_next = buddy_pkg::S_ASRCH;
          buddy_pkg::OP_FREE:  state_next = addr_ok ? buddy_pkg::S_FCHK : buddy_pkg::S_RESP;
          buddy_pkg::OP_QUERY: state_next = addr_ok ? buddy_pkg::S_QCHK : buddy_pkg::S_RESP;
          default:             state_next = buddy_pkg::S_RESP;
        endcase
      end
      buddy_pkg::S_ASRCH: begin
        if (!k_le) state_next = buddy_pkg::S_RESP;
        else if (head_k != '0) state_next = buddy_pkg::S_APOP;
      end
      buddy_pkg::S_APOP:   state_next = buddy_pkg::S_ASPLIT;
      buddy_pkg::S_ASPLIT: if (k <= ord_k) state_next = buddy_pkg::S_RESP;
      buddy_pkg::S_FCHK:
        state_next = (ao_q == ord1) ? buddy_pkg::S_FLOOP : buddy_pkg::S_RESP;
      buddy_pkg::S_FLOOP:
        state_next = (k < LEV_K) ? buddy_pkg::S_WRD : buddy_pkg::S_PUSH;
      buddy_pkg::S_WRD:
        state_next = (cur == '0) ? buddy_pkg::S_PUSH : buddy_pkg::S_WWT;
      buddy_pkg::S_WWT:
        state_next = (node == buddy) ? buddy_pkg::S_FLOOP : buddy_pkg::S_WRD;
      buddy_pkg::S_PUSH:   state_next = buddy_pkg::S_RESP;
      buddy_pkg::S_QCHK:   state_next = buddy_pkg::S_RESP;
      buddy_pkg::S_RESP:   if (rsp_go) state_next = buddy_pkg::S_IDLE;
      default:             state_next = buddy_pkg::S_IDLE;
    endcase
  end

  // Memory port controls
  always_comb begin
    nl_re = 1'b0; nl_raddr = '0;
    nl_we = 1'b0; nl_waddr = '0; nl_wdata = '0;
    ao_re = 1'b0; ao_raddr = '0;
    ao_we = 1'b0; ao_waddr = '0; ao_wdata = '0;
    unique case (state)
      buddy_pkg::S_CLR: begin
        ao_we = 1'b1; ao_waddr = clr;
      end
      buddy_pkg::S_DEC: begin
        ao_re = 1'b1; ao_raddr = dec_idx;
      end
      buddy_pkg::S_ASRCH: begin
        if (k_le && head_k != '0) begin
          nl_re = 1'b1; nl_raddr = head_idx;
        end
      end
      buddy_pkg::S_ASPLIT: begin
        if (k > ord_k) begin
          nl_we = 1'b1; nl_waddr = split_blk; nl_wdata = head_dn;
        end else begin
          ao_we = 1'b1; ao_waddr = idx; ao_wdata = ord1;
        end
      end
      buddy_pkg::S_FCHK: begin
        if (ao_q == ord1) begin
          ao_we = 1'b1; ao_waddr = idx;
        end
      end
      buddy_pkg::S_WRD: begin
        if (cur != '0) begin
          nl_re = 1'b1; nl_raddr = node;
        end
      end
      buddy_pkg::S_WWT: begin
        // unlink from the middle of the list
        if (node == buddy && prev != '0) begin
          nl_we = 1'b1; nl_waddr = IDX_W'(prev - LINK_W'(1)); nl_wdata = nl_rd;
        end
      end
      buddy_pkg::S_PUSH: begin
        nl_we = 1'b1; nl_waddr = blk; nl_wdata = head_k;
      end
      default: ;
    endcase
  end

  // State, list heads and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= buddy_pkg::S_CLR;
      clr       <= '0;
      out_valid <= 1'b0;
      link0_ok  <= 1'b0;
      for (int i = 0; i <= LEVELS; i++) heads[i] <= (i == LEVELS) ? LINK_W'(1) : '0;
    end else begin
      state <= state_next;
      if (nl_we && nl_waddr == '0) link0_ok <= 1'b1;
      if (out_valid && out_ready && state != buddy_pkg::S_RESP) out_valid <= 1'b0;
      unique case (state)
        buddy_pkg::S_CLR: clr <= clr + IDX_W'(1);
        buddy_pkg::S_IDLE: begin
          if (in_valid) begin
            r_op   <= op;
            r_ord  <= req_order;
            r_addr <= req_address;
          end
        end
        buddy_pkg::S_DEC: begin
          k          <= ord_k;
          idx        <= dec_idx;
          res_status <= buddy_pkg::ST_INVALID;
          res_baddr  <= 32'd0;
          res_border <= 4'd0;
        end
        buddy_pkg::S_ASRCH: begin
          if (!k_le) res_status <= buddy_pkg::ST_NOBLK;
          else if (head_k == '0) k <= k + KW'(1);
          else idx <= head_idx;
        end
        buddy_pkg::S_APOP: heads[k[HI_W-1:0]] <= nl_rd;
        buddy_pkg::S_ASPLIT: begin
          // push the upper half of each split onto the next order down
          if (k > ord_k) begin
            heads[k_dn[HI_W-1:0]] <= LINK_W'(split_blk) + LINK_W'(1);
            k <= k_dn;
          end else begin
            res_status <= buddy_pkg::ST_OK;
            res_baddr  <= pool_base + (32'(idx) << min_level);
          end
        end
        buddy_pkg::S_FCHK: begin
          if (ao_q == ord1) begin
            blk <= idx;
            k   <= ord_k;
          end
        end
        buddy_pkg::S_FLOOP: begin
          if (k < LEV_K) begin
            buddy <= blk ^ (IDX_W'(1) << k);
            prev  <= '0;
            cur   <= head_k;
          end
        end
        buddy_pkg::S_WWT: begin
          if (node == buddy) begin
            if (prev == '0) heads[k[HI_W-1:0]] <= nl_rd;
            if (buddy < blk) blk <= buddy;
            k <= k + KW'(1);
          end else begin
            prev <= cur;
            cur  <= nl_rd;
          end
        end
        buddy_pkg::S_PUSH: begin
          heads[k[HI_W-1:0]] <= LINK_W'(blk) + LINK_W'(1);
          res_status <= buddy_pkg::ST_OK;
        end
        buddy_pkg::S_QCHK: begin
          if (ao_q != '0) begin
            res_status <= buddy_pkg::ST_OK;
            res_border <= 4'(ao_q - KW'(1));
          end
        end
        buddy_pkg::S_RESP: begin
          if (rsp_go) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            block_address <= res_baddr;
            block_order   <= res_border;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // no request taken during the clearing pass
  a_clr_block: assert property (@(posedge clk) disable iff (rst)
    (state == buddy_pkg::S_CLR) |-> !in_ready)
    else $error("request accepted during clearing pass");

  // an accepted request always goes to decode
  a_accept_dec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == buddy_pkg::S_DEC))
    else $error("accepted request not decoded");

  // the link RAM is never read and written in the same cycle
  a_nl_port: assert property (@(posedge clk) disable iff (rst)
    !(nl_re && nl_we))
    else $error("link RAM read and write collide");

  // a response is only loaded when the output register is free
  a_rsp_load: assert property (@(posedge clk) disable iff (rst)
    (state == buddy_pkg::S_RESP && out_valid && !out_ready) |=> $stable(status))
    else $error("pending response overwritten");
`endif

endmodule
